[hw/rtl/skl_pkg.sv]
package skl_pkg;

	// list dimensions
	localparam int CAPACITY   = 16;
	localparam int KEY_BITS   = 32;
	localparam int ID_BITS    = 8;
	localparam int COUNT_BITS = $clog2(CAPACITY + 1);

	// request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_DUP       = 3'd4;

	// incoming request
	typedef struct packed {
		logic [1:0]          req_type;
		logic [ID_BITS-1:0]  item_id;
		logic [KEY_BITS-1:0] key;
	} skl_req_t;

	// outgoing result
	typedef struct packed {
		logic [2:0]            status;
		logic [COUNT_BITS-1:0] count;
		logic                  head_valid;
		logic [ID_BITS-1:0]    head_id;
		logic [KEY_BITS-1:0]   head_key;
	} skl_rsp_t;

	// one stored list entry
	typedef struct packed {
		logic [ID_BITS-1:0]  id;
		logic [KEY_BITS-1:0] key;
	} skl_entry_t;

	// broadcast control shared by every cell
	typedef struct packed {
		logic                sorted;
		logic                ins_en;
		logic                rm_en;
		logic [ID_BITS-1:0]  id;
		logic [KEY_BITS-1:0] key;
	} skl_ctl_t;

endpackage

[hw/rtl/skl_cell.sv]
module skl_cell (
	input  logic               clk,
	input  skl_pkg::skl_ctl_t   ctl,
	input  logic               valid,
	input  skl_pkg::skl_entry_t prev_entry,
	input  skl_pkg::skl_entry_t next_entry,
	input  logic               ins_in,
	input  logic               rm_in,
	output logic               ins_out,
	output logic               rm_out,
	output logic               match,
	output skl_pkg::skl_entry_t entry,
	output skl_pkg::skl_entry_t entry_nxt
);
	import skl_pkg::*;

	skl_entry_t entry_q;
	logic       gt;

	// local compares against the broadcast request
	assign gt    = valid && ctl.sorted && (entry_q.key > ctl.key);
	assign match = valid && (entry_q.id == ctl.id);

	// insert point is the first cell that is empty or holds a larger key
	assign ins_out = ins_in | gt | ~valid;
	// every cell from the matching one on pulls from its right neighbor
	assign rm_out  = rm_in | match;

	// next contents: shift right on insert, shift left on remove
	always_comb begin
		entry_nxt = entry_q;
		if (ctl.ins_en) begin
			if (ins_in) begin
				entry_nxt = prev_entry;
			end else if (ins_out) begin
				entry_nxt.id  = ctl.id;
				entry_nxt.key = ctl.key;
			end
		end else if (ctl.rm_en && rm_out) begin
			entry_nxt = next_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_nxt;
	end

	assign entry = entry_q;

endmodule

[hw/rtl/sorted_key_list_unit.sv]
// Sorted key list: holds up to CAPACITY (id, key) entries in list order in a
// row of cells, one entry per cell. A sorted insert lands after every entry
// with an equal or smaller key (an all-ones key always lands at the tail), an
// append lands at the tail, and a remove closes the gap left by the given id.
// Every request yields one result with status, new count and the head entry.
// The whole row compares and shifts in the cycle the request is accepted, and
// the result is registered for the next cycle, so a new request can be taken
// every cycle while the consumer keeps up. req_ready is high whenever the
// result register is empty or being drained; the ripple of the insert and
// remove flags along the row sets the cycle time.
module sorted_key_list_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  skl_pkg::skl_req_t  req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output skl_pkg::skl_rsp_t  rsp
);
	import skl_pkg::*;

	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] count_nxt;
	logic                  rsp_valid_q;
	skl_rsp_t              rsp_q;

	skl_ctl_t              ctl;
	skl_entry_t            entry     [CAPACITY];
	skl_entry_t            entry_nxt [CAPACITY];
	logic [CAPACITY-1:0]   cell_valid;
	logic [CAPACITY-1:0]   match_vec;
	logic [CAPACITY:0]     ins_chain;
	logic [CAPACITY:0]     rm_chain;

	logic                  accept;
	logic                  full;
	logic                  empty;
	logic                  any_match;
	logic                  ins_ok;
	logic                  rm_ok;
	logic [2:0]            status;

	assign req_ready = ~rsp_valid_q | rsp_ready;
	assign accept    = req_valid & req_ready;

	assign full      = (count_q == COUNT_BITS'(CAPACITY));
	assign empty     = (count_q == '0);
	assign any_match = |match_vec;

	// request decode and status
	always_comb begin
		ins_ok = 1'b0;
		rm_ok  = 1'b0;
		status = ST_OK;
		unique case (req.req_type)
			REQ_INSERT, REQ_APPEND: begin
				if (full) begin
					status = ST_FULL;
				end else if (any_match) begin
					status = ST_DUP;
				end else begin
					ins_ok = 1'b1;
				end
			end
			REQ_REMOVE: begin
				if (empty) begin
					status = ST_EMPTY;
				end else if (!any_match) begin
					status = ST_NOT_FOUND;
				end else begin
					rm_ok = 1'b1;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	// control broadcast to the row
	always_comb begin
		ctl.sorted = (req.req_type == REQ_INSERT) && (req.key != '1);
		ctl.ins_en = accept & ins_ok;
		ctl.rm_en  = accept & rm_ok;
		ctl.id     = req.item_id;
		ctl.key    = req.key;
	end

	// row of cells
	assign ins_chain[0] = 1'b0;
	assign rm_chain[0]  = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		skl_entry_t prev_e;
		skl_entry_t next_e;

		assign cell_valid[i] = (count_q > COUNT_BITS'(i));

		if (i == 0) begin : g_first
			assign prev_e = entry[i];
		end else begin : g_mid_prev
			assign prev_e = entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_e = entry[i];
		end else begin : g_mid_next
			assign next_e = entry[i+1];
		end

		skl_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.valid      (cell_valid[i]),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.ins_in     (ins_chain[i]),
			.rm_in      (rm_chain[i]),
			.ins_out    (ins_chain[i+1]),
			.rm_out     (rm_chain[i+1]),
			.match      (match_vec[i]),
			.entry      (entry[i]),
			.entry_nxt  (entry_nxt[i])
		);
	end

	// entry count
	always_comb begin
		count_nxt = count_q;
		if (ctl.ins_en) begin
			count_nxt = count_q + COUNT_BITS'(1);
		end else if (ctl.rm_en) begin
			count_nxt = count_q - COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (req_ready) begin
				rsp_valid_q <= req_valid;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status     <= status;
			rsp_q.count      <= count_nxt;
			rsp_q.head_valid <= (count_nxt != '0);
			rsp_q.head_id    <= (count_nxt != '0) ? entry_nxt[0].id : '0;
			rsp_q.head_key   <= (count_nxt != '0) ? entry_nxt[0].key : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_BITS'(CAPACITY))
		else $error("entry count above capacity");

	a_ids_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("id stored in more than one cell");

	a_one_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.ins_en, ctl.rm_en}))
		else $error("insert and remove committed together");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins_en |=> count_q == $past(count_q) + COUNT_BITS'(1))
		else $error("insert did not grow the list");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.head_valid == (rsp.count != '0)))
		else $error("head valid disagrees with count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_FULL) |-> rsp.count == COUNT_BITS'(CAPACITY))
		else $error("full status with list not full");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import skl_pkg::*;

	// request code the block treats as a no-op
	localparam logic [1:0]          REQ_NOP     = 2'd3;
	localparam logic [KEY_BITS-1:0] KEY_FOREVER = '1;
	localparam int                  IDLE_LIMIT  = 2000;
	localparam int                  PRINT_LIMIT = 40;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	skl_req_t req;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	skl_rsp_t rsp;

	// shadow copy of the list, in list order
	logic [ID_BITS-1:0]  shadow_ids  [CAPACITY];
	logic [KEY_BITS-1:0] shadow_keys [CAPACITY];
	int                  shadow_len = 0;

	// list views the block should report, oldest first
	skl_rsp_t predicted_views [$];

	int          mismatches  = 0;
	int          burst_left  = 0;
	int          idle_cycles = 0;
	logic [31:0] stall_pattern = '1;
	int          stall_age   = 0;

	sorted_key_list_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// position of an id in the shadow list, -1 when absent
	function automatic int shadow_find(logic [ID_BITS-1:0] id);
		int i;
		for (i = 0; i < shadow_len; i++) begin
			if (shadow_ids[i] == id)
				return i;
		end
		return -1;
	endfunction

	// apply one request to the shadow list and return the view that follows
	function automatic skl_rsp_t shadow_update(skl_req_t r);
		skl_rsp_t view;
		int       at;
		int       pos;
		int       i;
		view        = '0;
		view.status = ST_OK;
		at          = shadow_find(r.item_id);
		case (r.req_type)
			REQ_INSERT, REQ_APPEND: begin
				if (shadow_len >= CAPACITY) begin
					view.status = ST_FULL;
				end else if (at >= 0) begin
					view.status = ST_DUP;
				end else begin
					pos = shadow_len;
					// first entry with a strictly larger key, forever keys go last
					if (r.req_type == REQ_INSERT && r.key != KEY_FOREVER) begin
						for (i = shadow_len - 1; i >= 0; i--) begin
							if (shadow_keys[i] > r.key)
								pos = i;
						end
					end
					for (i = shadow_len; i > pos; i--) begin
						shadow_ids[i]  = shadow_ids[i-1];
						shadow_keys[i] = shadow_keys[i-1];
					end
					shadow_ids[pos]  = r.item_id;
					shadow_keys[pos] = r.key;
					shadow_len++;
				end
			end
			REQ_REMOVE: begin
				if (shadow_len == 0) begin
					view.status = ST_EMPTY;
				end else if (at < 0) begin
					view.status = ST_NOT_FOUND;
				end else begin
					for (i = at; i + 1 < shadow_len; i++) begin
						shadow_ids[i]  = shadow_ids[i+1];
						shadow_keys[i] = shadow_keys[i+1];
					end
					shadow_len--;
				end
			end
			default: begin
			end
		endcase
		view.count = COUNT_BITS'(shadow_len);
		if (shadow_len > 0) begin
			view.head_valid = 1'b1;
			view.head_id    = shadow_ids[0];
			view.head_key   = shadow_keys[0];
		end
		return view;
	endfunction

	function automatic skl_req_t make_req(logic [1:0] kind, logic [ID_BITS-1:0] id,
			logic [KEY_BITS-1:0] key);
		skl_req_t r;
		r.req_type = kind;
		r.item_id  = id;
		r.key      = key;
		return r;
	endfunction

	// mostly a small id pool so duplicates and hits are common
	function automatic logic [ID_BITS-1:0] random_id();
		if ($urandom_range(0, 3) != 0)
			return ID_BITS'($urandom_range(0, 31));
		return ID_BITS'($urandom_range(0, 255));
	endfunction

	function automatic skl_req_t random_request(int remove_pct);
		skl_req_t r;
		int       roll;
		roll = $urandom_range(0, 99);
		// key mix: extremes, tight range for ties, full range
		case ($urandom_range(0, 5))
			0:       r.key = '0;
			1:       r.key = KEY_FOREVER;
			2:       r.key = KEY_FOREVER - 1;
			3:       r.key = KEY_BITS'($urandom_range(0, 7));
			default: r.key = KEY_BITS'($urandom);
		endcase
		if (roll < remove_pct) begin
			r.req_type = REQ_REMOVE;
			if (shadow_len > 0 && $urandom_range(0, 3) != 0)
				r.item_id = shadow_ids[$urandom_range(0, shadow_len - 1)];
			else
				r.item_id = random_id();
		end else if (roll < 95) begin
			r.req_type = ($urandom_range(0, 3) == 0) ? REQ_APPEND : REQ_INSERT;
			r.item_id  = random_id();
		end else begin
			r.req_type = REQ_NOP;
			r.item_id  = ID_BITS'($urandom);
		end
		return r;
	endfunction

	// send one request, in bursts with random gaps between them
	task automatic send_request(input skl_req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 20);
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		burst_left--;
		predicted_views.push_back(shadow_update(r));
	endtask

	// sender holds off until every predicted view has come back
	task automatic wait_for_results();
		req_valid <= 1'b0;
		burst_left = 0;
		while (predicted_views.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [KEY_BITS-1:0] got,
			input logic [KEY_BITS-1:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// removes and no-ops on an empty list
	task automatic test_empty_list();
		send_request(make_req(REQ_REMOVE, 8'd5, '0));
		send_request(make_req(REQ_NOP, 8'hff, KEY_FOREVER));
	endtask

	// ordering: ties land after, forever keys and appends land at the tail
	task automatic test_sorted_order();
		send_request(make_req(REQ_INSERT, 8'd0, 32'd100));
		send_request(make_req(REQ_INSERT, 8'hff, 32'd100));
		send_request(make_req(REQ_INSERT, 8'd1, '0));
		send_request(make_req(REQ_INSERT, 8'd2, KEY_FOREVER));
		send_request(make_req(REQ_INSERT, 8'd3, KEY_FOREVER - 1));
		send_request(make_req(REQ_APPEND, 8'd4, '0));
		send_request(make_req(REQ_INSERT, 8'd5, KEY_FOREVER));
	endtask

	task automatic test_duplicate_ids();
		send_request(make_req(REQ_INSERT, 8'hff, 32'd7));
		send_request(make_req(REQ_APPEND, 8'd1, KEY_FOREVER));
	endtask

	// head, middle and tail removal, absent id, no-op on a live list
	task automatic test_removal();
		send_request(make_req(REQ_REMOVE, 8'd1, '0));
		send_request(make_req(REQ_REMOVE, 8'd3, KEY_FOREVER));
		send_request(make_req(REQ_REMOVE, 8'd5, '0));
		send_request(make_req(REQ_REMOVE, 8'd77, '0));
		send_request(make_req(REQ_NOP, 8'd3, 32'h5a5a_a5a5));
	endtask

	// fill to capacity, then both insert kinds must report full
	task automatic test_full_list();
		int id;
		for (id = 10; shadow_len < CAPACITY; id++)
			send_request(make_req(REQ_APPEND, ID_BITS'(id), KEY_BITS'($urandom)));
		send_request(make_req(REQ_INSERT, 8'd200, '0));
		send_request(make_req(REQ_APPEND, 8'd0, '0));
	endtask

	task automatic test_random_traffic(input int items, input int remove_pct);
		int n;
		for (n = 0; n < items; n++)
			send_request(random_request(remove_pct));
	endtask

	// receiver stalls on a rotating pattern, re-drawn now and then
	always @(posedge clk) begin
		if (stall_age == 0) begin
			stall_pattern <= ($urandom_range(0, 3) == 0) ? 32'hffff_ffff : ($urandom | 32'h1);
			stall_age     <= $urandom_range(16, 96);
		end else begin
			stall_pattern <= {stall_pattern[0], stall_pattern[31:1]};
			stall_age     <= stall_age - 1;
		end
		rsp_ready <= stall_pattern[0];
	end

	// compare each result with the oldest predicted view
	always @(posedge clk) begin
		skl_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (predicted_views.size() == 0) begin
				report_mismatch("unexpected result", rsp.head_key, '0);
			end else begin
				want = predicted_views.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", KEY_BITS'(rsp.status),
						KEY_BITS'(want.status));
				if (rsp.count !== want.count)
					report_mismatch("count", KEY_BITS'(rsp.count), KEY_BITS'(want.count));
				if (rsp.head_valid !== want.head_valid)
					report_mismatch("head_valid", KEY_BITS'(rsp.head_valid),
						KEY_BITS'(want.head_valid));
				if (rsp.head_id !== want.head_id)
					report_mismatch("head_id", KEY_BITS'(rsp.head_id),
						KEY_BITS'(want.head_id));
				if (rsp.head_key !== want.head_key)
					report_mismatch("head_key", rsp.head_key, want.head_key);
			end
		end
	end

	// watchdog on cycles with no request or result accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_sorted_order();
		test_duplicate_ids();
		test_removal();
		test_full_list();
		test_random_traffic(200, 35);
		wait_for_results();
		test_random_traffic(120, 65);
		test_random_traffic(180, 40);

		// drain and let the block settle
		wait_for_results();
		repeat (10) @(posedge clk);
		if (predicted_views.size() != 0)
			report_mismatch("missing results", KEY_BITS'(predicted_views.size()), '0);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
